// ===== hw/rtl/toma_pkg.sv =====
// shared types and constants for the ticket order mutex arbiter
// used by toma_cell and ticket_order_mutex_arbiter; depends on nothing

package toma_pkg;

    // request codes
    localparam logic [1:0] OP_ACQUIRE = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_POLL    = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_PHASE    = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;
    localparam logic [1:0] ST_UNUSED   = 2'd3;

    // register file: one 32-bit register, word addressed by paddr[2]
    localparam int         APB_ADDR_BITS      = 3;
    localparam int         APB_DATA_BITS      = 32;
    localparam logic       REG_CLIENT_COUNT   = 1'b0;
    localparam int         CLIENT_COUNT_BITS  = 4;
    localparam logic [3:0] CLIENT_COUNT_RESET = 4'd8;

    typedef struct packed {
        logic [1:0] operation;
        logic [2:0] client;
    } t_in_item;

    typedef struct packed {
        logic        granted;
        logic [15:0] ticket_value;
        logic [1:0]  status;
    } t_out_item;

    // control half of the scan wave handed from cell to cell
    typedef struct packed {
        logic valid;
        logic beaten;
    } t_scan;

endpackage

// ===== hw/rtl/toma_cell.sv =====
// one client slot of the arbiter: holds that client's ticket and folds it
// into the scan wave (running maximum, lower-ticket test); uses toma_pkg

module toma_cell #(
    parameter int TICKET_BITS = 16,
    parameter int IDX_BITS    = 3,
    parameter int CELL_IDX    = 0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  toma_pkg::t_scan           i_scan,
    input  logic [TICKET_BITS-1:0]    i_top,
    output toma_pkg::t_scan           o_scan,
    output logic [TICKET_BITS-1:0]    o_top,
    input  logic                      i_active,
    input  logic [IDX_BITS-1:0]       i_me,
    input  logic [TICKET_BITS-1:0]    i_mine,
    input  logic                      i_wr_en,
    input  logic [TICKET_BITS-1:0]    i_wr_ticket,
    output logic [TICKET_BITS-1:0]    o_ticket
);

    localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(CELL_IDX);

    logic [TICKET_BITS-1:0] r_ticket;
    toma_pkg::t_scan        r_scan;
    toma_pkg::t_scan        n_scan;
    logic [TICKET_BITS-1:0] r_top;
    logic [TICKET_BITS-1:0] n_top;
    logic                   w_is_me;
    logic                   w_lower;
    logic                   w_beats;

    always_comb begin
        w_is_me = (i_me == MY_IDX);
        // ties go to the lower index
        w_lower = (r_ticket < i_mine) || ((r_ticket == i_mine) && (MY_IDX < i_me));
        w_beats = i_active && !w_is_me && (r_ticket != '0) && w_lower;
        n_top   = (i_active && (r_ticket > i_top)) ? r_ticket : i_top;
        n_scan.valid  = i_scan.valid;
        n_scan.beaten = i_scan.beaten | w_beats;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticket <= '0;
            r_scan   <= '0;
        end else begin
            r_scan <= n_scan;
            if (i_wr_en && w_is_me) begin
                r_ticket <= i_wr_ticket;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_top <= n_top;
    end

    assign o_scan   = r_scan;
    assign o_top    = r_top;
    assign o_ticket = r_ticket;

endmodule

// ===== hw/rtl/ticket_order_mutex_arbiter.sv =====
// top level of the ticket order mutex arbiter: request control, register port
// and the row of toma_cell slots; uses toma_pkg and toma_cell

// Bakery-style hardware mutex. Each client slot keeps a ticket (0 = idle);
// acquire hands out one above the largest active ticket, release clears the
// ticket of the client holding the lowest one, poll reports whether the client
// holds the lowest ticket (ties to the lower index). Requests are handled one
// at a time: an accepted item first fetches the client's ticket (S_LOAD), then
// the scan wave walks the row of client cells, registered once per cell
// (S_SCAN), and in S_DONE the ticket is written back and the result registered,
// waiting there while the output register still holds an untaken result; the
// next item is taken only after the return to idle. A refused out-of-range
// request skips the fetch and the scan and goes straight to S_DONE.
// The result sits in an output register, so the next item is taken while the
// previous result still waits. client_count lives at byte address 0 and may
// only be changed while no request is in flight.

module ticket_order_mutex_arbiter #(
    parameter int MAX_CLIENTS = 8,
    parameter int TICKET_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    input  toma_pkg::t_in_item                    i_in_data,
    output logic                                  o_in_stall,
    output logic                                  o_out_valid,
    output toma_pkg::t_out_item                   o_out_data,
    input  logic                                  i_out_stall,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [toma_pkg::APB_ADDR_BITS-1:0]    paddr,
    input  logic [toma_pkg::APB_DATA_BITS-1:0]    pwdata,
    output logic [toma_pkg::APB_DATA_BITS-1:0]    prdata,
    output logic                                  pready
);

    localparam int IDX_BITS = $clog2(MAX_CLIENTS);
    localparam int CNT_BITS = $clog2(MAX_CLIENTS + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOAD = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state r_state;

    logic [toma_pkg::CLIENT_COUNT_BITS-1:0] r_cnt;
    logic [CNT_BITS-1:0]                    w_n;

    logic [1:0]             r_op;
    logic [IDX_BITS-1:0]    r_me;
    logic                   r_oor;
    logic [TICKET_BITS-1:0] r_mine;
    logic [TICKET_BITS-1:0] r_top;
    logic                   r_beaten;
    logic                   r_launch;

    logic                   r_out_valid;
    toma_pkg::t_out_item    r_out;
    toma_pkg::t_out_item    n_out;

    logic                   w_in_acc;
    logic                   w_oor;
    logic                   w_slot_free;
    logic                   w_wr_en;
    logic                   w_wr_need;
    logic [TICKET_BITS-1:0] w_wr_ticket;
    logic [TICKET_BITS-1:0] w_tv;
    logic [TICKET_BITS+15:0] w_tv_ext;
    logic                   w_holds;
    logic                   w_cfg_wr;

    toma_pkg::t_scan        w_scan [0:MAX_CLIENTS];
    logic [TICKET_BITS-1:0] w_top  [0:MAX_CLIENTS];
    logic [TICKET_BITS-1:0] w_tickets [0:MAX_CLIENTS-1];
    logic [MAX_CLIENTS-1:0] w_active;
    logic [MAX_CLIENTS:0]   w_wave;

    // register port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == toma_pkg::REG_CLIENT_COUNT);
    assign prdata   = (paddr[2] == toma_pkg::REG_CLIENT_COUNT)
                    ? {{(toma_pkg::APB_DATA_BITS - toma_pkg::CLIENT_COUNT_BITS){1'b0}}, r_cnt}
                    : '0;

    // active client count, capped at the number of cells
    always_comb begin
        if (int'(r_cnt) > MAX_CLIENTS) begin
            w_n = CNT_BITS'(MAX_CLIENTS);
        end else begin
            w_n = CNT_BITS'(r_cnt);
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_oor       = (int'(i_in_data.client) >= int'(w_n));
    assign w_slot_free = !r_out_valid || !i_out_stall;

    // row of client cells, wave enters at cell 0
    assign w_scan[0].valid  = r_launch;
    assign w_scan[0].beaten = 1'b0;
    assign w_top[0]         = '0;

    for (genvar k = 0; k < MAX_CLIENTS; k++) begin : g_cell
        assign w_active[k] = (k < int'(w_n));

        toma_cell #(
            .TICKET_BITS (TICKET_BITS),
            .IDX_BITS    (IDX_BITS),
            .CELL_IDX    (k)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_scan      (w_scan[k]),
            .i_top       (w_top[k]),
            .o_scan      (w_scan[k+1]),
            .o_top       (w_top[k+1]),
            .i_active    (w_active[k]),
            .i_me        (r_me),
            .i_mine      (r_mine),
            .i_wr_en     (w_wr_en),
            .i_wr_ticket (w_wr_ticket),
            .o_ticket    (w_tickets[k])
        );
    end

    for (genvar k = 0; k <= MAX_CLIENTS; k++) begin : g_wave
        assign w_wave[k] = w_scan[k].valid;
    end

    // result of the step from the scan summary
    always_comb begin
        w_holds     = (r_mine != '0) && !r_beaten;
        w_wr_need   = 1'b0;
        w_wr_ticket = '0;
        w_tv        = r_mine;
        n_out.granted = w_holds;
        n_out.status  = toma_pkg::ST_OK;
        if (r_oor) begin
            w_tv          = '0;
            n_out.granted = 1'b0;
            n_out.status  = toma_pkg::ST_PHASE;
        end else begin
            case (r_op)
                toma_pkg::OP_ACQUIRE: begin
                    if (r_mine != '0) begin
                        n_out.status = toma_pkg::ST_PHASE;
                    end else if (&r_top) begin
                        n_out.status  = toma_pkg::ST_OVERFLOW;
                        n_out.granted = 1'b0;
                    end else begin
                        // new ticket is above every other, so it wins only alone
                        w_wr_need     = 1'b1;
                        w_wr_ticket   = r_top + TICKET_BITS'(1);
                        w_tv          = w_wr_ticket;
                        n_out.granted = (r_top == '0);
                    end
                end
                toma_pkg::OP_RELEASE: begin
                    n_out.granted = 1'b0;
                    if (w_holds) begin
                        w_wr_need = 1'b1;
                        w_tv      = '0;
                    end else begin
                        n_out.status = toma_pkg::ST_PHASE;
                    end
                end
                toma_pkg::OP_POLL: begin
                    if (r_mine == '0) begin
                        n_out.status = toma_pkg::ST_PHASE;
                    end
                end
                default: begin
                    n_out.status = toma_pkg::ST_PHASE;
                end
            endcase
        end
        w_tv_ext           = {16'b0, w_tv};
        n_out.ticket_value = w_tv_ext[15:0];
    end

    assign w_wr_en = (r_state == S_DONE) && w_slot_free && w_wr_need;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_launch    <= 1'b0;
            r_cnt       <= toma_pkg::CLIENT_COUNT_RESET;
        end else begin
            r_launch <= (r_state == S_LOAD);
            if (w_cfg_wr) begin
                r_cnt <= pwdata[toma_pkg::CLIENT_COUNT_BITS-1:0];
            end
            if (r_state == S_DONE && w_slot_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= w_oor ? S_DONE : S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (w_scan[MAX_CLIENTS].valid) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_slot_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op  <= i_in_data.operation;
            r_me  <= IDX_BITS'(i_in_data.client);
            r_oor <= w_oor;
        end
        if (r_state == S_LOAD) begin
            r_mine <= w_tickets[r_me];
        end
        if (r_state == S_SCAN && w_scan[MAX_CLIENTS].valid) begin
            r_top    <= w_top[MAX_CLIENTS];
            r_beaten <= w_scan[MAX_CLIENTS].beaten;
        end
        if (r_state == S_DONE && w_slot_free) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_wave_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_wave))
        else $error("more than one scan wave in the cell row");

    a_wave_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_scan[MAX_CLIENTS].valid |-> (r_state == S_SCAN))
        else $error("scan wave left the row outside the scan state");

    a_accept_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_LOAD || r_state == S_DONE))
        else $error("accepted item did not start a step");

    a_done_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && w_slot_free) |=> o_out_valid)
        else $error("finished step produced no result");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status != toma_pkg::ST_UNUSED))
        else $error("result carries an unused status code");

endmodule
